// ===== hdl/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, constants and helpers of the line substring search core.
// ----------------------------------------------------------------------------
package lss_pkg;

    // pattern window
    localparam int MAX_PATTERN = 32;
    localparam int PAT_REGS    = 4;
    localparam int PAT_WORD_W  = 64;
    localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 6;
    localparam int LINE_W      = 32;

    // configuration port
    localparam int CFG_IDX_W   = 3;

    // event queue between front and back, depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]        NEWLINE_CHAR = 8'd10;
    localparam logic [LINE_W-1:0] LINE_FIRST   = LINE_W'(1);
    localparam logic [LINE_W-1:0] LINE_LAST    = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_PAT_LEN   = 3'd4,
        CFG_IGN_CASE  = 3'd5
    } cfg_reg_t;

    // per-byte classification handed from front to back
    typedef struct packed {
        logic match_hit;   // pattern ends at this byte
        logic line_end;    // byte closes the line
        logic text_end;    // byte closes the text
    } lss_event_t;

    // fold upper-case ascii letters to lower case when enabled
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ign);
        logic [7:0] r;
        r = c;
        if (ign && (c >= 8'h41) && (c <= 8'h5A))
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== hdl/line_substring_search_core.sv =====
// ----------------------------------------------------------------------------
// line_substring_search_core
// Streaming search of a configured pattern in each text line.
// ----------------------------------------------------------------------------
// path: a closing byte's event is registered in the event queue, then the back
//   registers the line number into the result reg once that reg is free or popped
// throughput: one byte per cycle while full is low, set by the combinational
//   window compare; full rises only when the four-entry event queue backs up behind pop
// reset: asynchronous, clears queue, line flag, fill count, result valid;
//   line counter to 1, pattern to zero, length to 1, exact matching
module line_substring_search_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [lss_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [lss_pkg::PAT_WORD_W-1:0]  wr_data,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      text_byte,
    input  logic                            end_of_text,
    output logic                            empty,
    input  logic                            pop,
    output logic [lss_pkg::LINE_W-1:0]      line_number
);
    import lss_pkg::*;

    lss_event_t front_evt;
    lss_event_t head_evt;
    logic       accept;
    logic       q_empty;
    logic       evt_take;

    assign accept = push && !full;

    // front: window and compare
    lss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .evt         (front_evt)
    );

    // event queue
    lss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_evt),
        .full    (full),
        .rd_en   (evt_take),
        .rd_data (head_evt),
        .empty   (q_empty)
    );

    // back: line tracking and result
    lss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt_valid   (!q_empty),
        .evt         (head_evt),
        .evt_take    (evt_take),
        .empty       (empty),
        .pop         (pop),
        .line_number (line_number)
    );

endmodule

// ===== hdl/lss_front.sv =====
// ----------------------------------------------------------------------------
// lss_front
// Holds the configuration, shifts each byte into the line window, compares
// the pattern at the newest position and classifies the byte.
// ----------------------------------------------------------------------------
module lss_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [lss_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [lss_pkg::PAT_WORD_W-1:0]    wr_data,
    input  logic                              accept,
    input  logic [7:0]                        text_byte,
    input  logic                              end_of_text,
    output lss_pkg::lss_event_t               evt
);
    import lss_pkg::*;

    logic [PAT_WORD_W-1:0] pat_words_reg [PAT_REGS];
    logic [LEN_W-1:0]      pat_len_reg;
    logic                  ign_case_reg;

    logic [7:0]            win_reg  [MAX_PATTERN];
    logic [7:0]            win_next [MAX_PATTERN];
    logic [LEN_W-1:0]      fill_reg;
    logic [LEN_W-1:0]      fill_next;

    logic [7:0]            pat_bytes [MAX_PATTERN];
    logic [LEN_W-1:0]      len_eff;
    logic                  all_eq;
    logic                  line_end;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAT_REGS; i++)
            begin
                pat_words_reg[i] <= '0;
            end
            pat_len_reg  <= LEN_W'(1);
            ign_case_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                CFG_PAT_0_7:   pat_words_reg[0] <= wr_data;
                CFG_PAT_8_15:  pat_words_reg[1] <= wr_data;
                CFG_PAT_16_23: pat_words_reg[2] <= wr_data;
                CFG_PAT_24_31: pat_words_reg[3] <= wr_data;
                CFG_PAT_LEN:   pat_len_reg      <= wr_data[LEN_W-1:0];
                CFG_IGN_CASE:  ign_case_reg     <= wr_data[0];
                default:       ;
            endcase
        end
    end

    // pattern bytes and clamped length
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pat_bytes[i] = pat_words_reg[i >> 3][(i & 7) * 8 +: 8];
        end
        len_eff = (pat_len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_reg;
    end

    // window after this byte, newest at slot 0
    always_comb
    begin
        win_next[0] = text_byte;
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            win_next[j] = win_reg[j-1];
        end
        line_end  = (text_byte == NEWLINE_CHAR) || end_of_text;
        fill_next = (fill_reg == LEN_W'(MAX_PATTERN)) ? fill_reg : fill_reg + LEN_W'(1);
    end

    // parallel compare of all active slots
    always_comb
    begin
        logic             active;
        logic [LEN_W-1:0] idx;
        all_eq = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            active = LEN_W'(j) < len_eff;
            idx    = len_eff - LEN_W'(j) - LEN_W'(1);
            if (active && (fold_byte(pat_bytes[idx[PAT_IDX_W-1:0]], ign_case_reg)
                           != fold_byte(win_next[j], ign_case_reg)))
            begin
                all_eq = 1'b0;
            end
        end
        evt.match_hit = all_eq && (fill_next >= len_eff);
        evt.line_end  = line_end;
        evt.text_end  = end_of_text;
    end

    // window shift, payload only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                win_reg[j] <= win_next[j];
            end
        end
    end

    // bytes seen in the current line, gates stale slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= line_end ? '0 : fill_next;
        end
    end

endmodule

// ===== hdl/lss_queue.sv =====
// ----------------------------------------------------------------------------
// lss_queue
// Short event queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module lss_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  lss_pkg::lss_event_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output lss_pkg::lss_event_t rd_data,
    output logic                empty
);
    import lss_pkg::*;

    lss_event_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign full    = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/lss_back.sv =====
// ----------------------------------------------------------------------------
// lss_back
// Tracks the per-line match flag and the line counter, and holds the
// result register seen on the output side.
// ----------------------------------------------------------------------------
module lss_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      evt_valid,
    input  lss_pkg::lss_event_t       evt,
    output logic                      evt_take,
    output logic                      empty,
    input  logic                      pop,
    output logic [lss_pkg::LINE_W-1:0] line_number
);
    import lss_pkg::*;

    logic              hit_reg;
    logic              hit_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [LINE_W-1:0] out_line_reg;
    logic              emit;
    logic              line_hit;

    assign evt_take    = evt_valid && (!out_valid_reg || pop);
    assign empty       = !out_valid_reg;
    assign line_number = out_line_reg;

    // line bookkeeping
    always_comb
    begin
        line_hit  = hit_reg || evt.match_hit;
        emit      = evt_take && evt.line_end && line_hit;
        hit_next  = hit_reg;
        line_next = line_reg;
        if (evt_take)
        begin
            hit_next = evt.line_end ? 1'b0 : line_hit;
            if (evt.text_end)
            begin
                line_next = LINE_FIRST;
            end
            else if (evt.line_end && (line_reg != LINE_LAST))
            begin
                line_next = line_reg + LINE_W'(1);
            end
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            line_reg      <= LINE_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hit_reg       <= hit_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_line_reg <= line_reg;
        end
    end

endmodule

// ===== hdl/lss_checker.sv =====
// ----------------------------------------------------------------------------
// lss_checker
// Port-level checks of the line substring search core, bound to the top.
// ----------------------------------------------------------------------------
module lss_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            push,
    input logic                            full,
    input logic                            empty,
    input logic                            pop,
    input logic [lss_pkg::LINE_W-1:0]      line_number
);
    import lss_pkg::*;

    // nothing to deliver right after reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown right after reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(line_number)))
        else $error("waiting result changed or vanished");

    // line numbers start at one
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (line_number != '0))
        else $error("line number zero delivered");

    // queue cannot fill while results drain and no bytes arrive
    a_full_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !push) |=> !full)
        else $error("full raised without input");

endmodule

bind line_substring_search_core lss_checker u_lss_checker (.*);

// ===== test/tb_line_substring_search_core.sv =====
// ----------------------------------------------------------------------------
// tb_line_substring_search_core
// Self-checking bench for the streaming line search core. Text bytes are
// pushed through the input queue while a local line tracker predicts which
// line numbers must come out. Every popped line number is checked against the
// oldest prediction. A short directed section is followed by randomized setups
// over lengths 0-10, 17-33 and 63, both case modes and several idle patterns.
// ----------------------------------------------------------------------------
module tb_line_substring_search_core;

    timeunit 1ns;
    timeprecision 1ps;

    import lss_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_ITEMS    = 1250;
    localparam int RAND_SETUPS   = 12;

    // register indexes that the core must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] LOWER_A  = 8'h61;
    localparam logic [7:0] LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum int {
        ALPHA_FULL,
        ALPHA_MIXED_CASE,
        ALPHA_TWO_LETTER,
        ALPHA_EXTREME
    } alphabet_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       closes_text;
    } text_item_t;

    // dut interface
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [PAT_WORD_W-1:0] wr_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            text_byte = '0;
    logic                  end_of_text = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [LINE_W-1:0]     line_number;

    // stimulus and scoreboard
    text_item_t        text_pending[$];
    logic [LINE_W-1:0] line_nums_due[$];
    logic [7:0]        pat_src [MAX_PATTERN];
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                items_queued = 0;
    int                items_seen = 0;
    int                results_checked = 0;
    int                setups_run = 0;
    int                errors = 0;
    int                cycle_count = 0;
    bit                in_took = 1'b0;
    text_item_t        next_item;
    logic [LINE_W-1:0] due_line;

    // line tracker state and its copy of the registers
    logic [7:0]            win_bytes [MAX_PATTERN];
    int unsigned           line_fill;
    bit                    line_hit;
    logic [LINE_W-1:0]     cur_line;
    logic [PAT_WORD_W-1:0] pat_word [PAT_REGS];
    logic [LEN_W-1:0]      pat_len;
    logic                  ign_case;

    line_substring_search_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop),
        .line_number (line_number)
    );

    // clock
    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ascii letter folding as the core does it when case is ignored
    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (ign_case && (c >= UPPER_A) && (c <= UPPER_Z))
        begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

    function automatic int used_len();
        int n;
        n = int'(pat_len);
        if (n > MAX_PATTERN)
        begin
            n = MAX_PATTERN;
        end
        return n;
    endfunction

    task automatic clear_line_state();
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_bytes[i] = '0;
        end
        line_fill = 0;
        line_hit  = 1'b0;
    endtask

    task automatic reset_tracker();
        for (int i = 0; i < PAT_REGS; i++)
        begin
            pat_word[i] = '0;
        end
        pat_len  = LEN_W'(1);
        ign_case = 1'b0;
        clear_line_state();
        cur_line = LINE_FIRST;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_WORD_W-1:0] data);
        case (idx)
            CFG_PAT_0_7:   pat_word[0] = data;
            CFG_PAT_8_15:  pat_word[1] = data;
            CFG_PAT_16_23: pat_word[2] = data;
            CFG_PAT_24_31: pat_word[3] = data;
            CFG_PAT_LEN:   pat_len = data[LEN_W-1:0];
            CFG_IGN_CASE:  ign_case = data[0];
            default:       ;
        endcase
    endtask

    // shift one byte into the window, compare, close the line when it ends
    task automatic track_byte(input logic [7:0] b, input logic closes);
        int  n;
        bit  same;
        logic [7:0] pb;
        for (int i = MAX_PATTERN - 1; i > 0; i--)
        begin
            win_bytes[i] = win_bytes[i-1];
        end
        win_bytes[0] = b;
        if (line_fill < MAX_PATTERN)
        begin
            line_fill++;
        end
        n = used_len();
        if (line_fill >= n)
        begin
            same = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                pb = pat_word[i / 8][(i % 8) * 8 +: 8];
                if (lower_ascii(pb) != lower_ascii(win_bytes[n - 1 - i]))
                begin
                    same = 1'b0;
                end
            end
            if (same)
            begin
                line_hit = 1'b1;
            end
        end
        if ((b == NEWLINE_CHAR) || closes)
        begin
            if (line_hit)
            begin
                line_nums_due.push_back(cur_line);
            end
            clear_line_state();
            if (closes)
            begin
                cur_line = LINE_FIRST;
            end
            else if (cur_line != LINE_LAST)
            begin
                cur_line = cur_line + LINE_W'(1);
            end
        end
    endtask

    // monitor: register writes, result check, input transaction tracking
    always @(posedge clk)
    begin
        cycle_count++;
        in_took = 1'b0;
        if (rst_n)
        begin
            if (wr_en)
            begin
                apply_reg(wr_index, wr_data);
            end
            if (pop && !empty)
            begin
                if (line_nums_due.size() == 0)
                begin
                    $display("%0t: unexpected line_number, expected none, actual %0d",
                             $time, line_number);
                    errors++;
                end
                else
                begin
                    due_line = line_nums_due.pop_front();
                    if (line_number !== due_line)
                    begin
                        $display("%0t: line_number mismatch, expected %0d, actual %0d",
                                 $time, due_line, line_number);
                        errors++;
                    end
                    results_checked++;
                end
            end
            if (push && !full)
            begin
                in_took = 1'b1;
                track_byte(text_byte, end_of_text);
                items_seen++;
            end
        end
    end

    // driver: next text byte once the current transaction is taken
    always @(negedge clk)
    begin
        if (rst_n && (in_took || !push))
        begin
            if ((text_pending.size() > 0) && ($urandom_range(0, 99) >= send_idle_pct))
            begin
                next_item   = text_pending.pop_front();
                push        <= 1'b1;
                text_byte   <= next_item.ch;
                end_of_text <= next_item.closes_text;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("[line_substring_search_core] ERROR");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_WORD_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
    endtask

    task automatic end_writes();
        @(negedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_item(input logic [7:0] c, input logic closes);
        text_pending.push_back('{ch: c, closes_text: closes});
        items_queued++;
    endtask

    // wait until every byte is taken and every line number has come out
    task automatic wait_quiet();
        while ((items_seen != items_queued) || (line_nums_due.size() != 0))
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idle(input idle_mode_t m);
        case (m)
            IDLE_SENDER:
            begin
                send_idle_pct  = 57;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 57;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = 26;
                recv_stall_pct = 26;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    function automatic logic [7:0] pick_char(input alphabet_t mode);
        logic [7:0] c;
        case (mode)
            ALPHA_MIXED_CASE:
            begin
                case ($urandom_range(0, 9))
                    0: c = 8'h61;   // a
                    1: c = 8'h41;   // A
                    2: c = 8'h62;   // b
                    3: c = 8'h42;   // B
                    4: c = 8'h7A;   // z
                    5: c = 8'h5A;   // Z
                    6: c = 8'h40;   // just below A
                    7: c = 8'h5B;   // just above Z
                    8: c = 8'h60;   // just below a
                    default: c = 8'h7B;   // just above z
                endcase
            end
            ALPHA_TWO_LETTER: c = $urandom_range(0, 1) ? 8'h61 : 8'h62;
            ALPHA_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0: c = 8'h00;
                    1: c = 8'hFF;
                    2: c = 8'h7F;
                    default: c = 8'h80;
                endcase
            end
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // one text line: noise, full and partial pattern copies, then a terminator
    task automatic add_random_line(input alphabet_t mode);
        int body;
        int k;
        int n;
        int m;
        logic [7:0] c;
        bit closes;
        body = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 90) : $urandom_range(0, 12);
        n = used_len();
        k = 0;
        while (k < body)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n;
                for (int i = 0; i < m; i++)
                begin
                    c = pat_src[i];
                    if ((((c >= UPPER_A) && (c <= UPPER_Z)) || ((c >= LOWER_A) && (c <= LOWER_Z)))
                        && ($urandom_range(0, 2) == 0))
                    begin
                        c = c ^ CASE_GAP;
                    end
                    add_item(c, 1'b0);
                end
                k += (m == 0) ? 1 : m;
            end
            else
            begin
                c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : pick_char(mode);
                add_item(c, 1'b0);
                k++;
            end
        end
        closes = ($urandom_range(0, 9) == 0);
        c = (closes && $urandom_range(0, 1)) ? pick_char(mode) : NEWLINE_CHAR;
        add_item(c, closes);
    endtask

    task automatic run_random_setup(input int k);
        alphabet_t        mode;
        int               len;
        int               target;
        logic [PAT_WORD_W-1:0] w;
        mode = alphabet_t'(k % 4);
        case (k)
            0: len = MAX_PATTERN;
            1: len = 1;
            2: len = 0;
            3: len = 63;
            4: len = MAX_PATTERN + 1;
            5: len = $urandom_range(17, MAX_PATTERN);
            default: len = $urandom_range(2, 10);
        endcase
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pat_src[i] = (k == 7) ? 8'hFF : pick_char(mode);
        end
        // pattern words
        for (int r = 0; r < PAT_REGS; r++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                w[b * 8 +: 8] = pat_src[r * 8 + b];
            end
            write_reg(CFG_IDX_W'(int'(CFG_PAT_0_7) + r), w);
        end
        w = {$urandom, $urandom};
        w[LEN_W-1:0] = LEN_W'(len);
        write_reg(CFG_PAT_LEN, w);
        w = {$urandom, $urandom};
        w[0] = (k == 1) ? 1'b1 : (k == 2) ? 1'b0 : 1'($urandom_range(0, 1));
        write_reg(CFG_IGN_CASE, w);
        if ((k % 3) == 0)
        begin
            write_reg((k % 2) ? CFG_SPARE_7 : CFG_SPARE_6, {$urandom, $urandom});
        end
        end_writes();
        set_idle(idle_mode_t'(k % 4));
        target = items_queued + RAND_ITEMS / RAND_SETUPS;
        while (items_queued < target)
        begin
            add_random_line(mode);
        end
        wait_quiet();
        setups_run++;
    endtask

    // main sequence
    initial
    begin
        reset_tracker();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_idle(IDLE_NONE);

        // reset setup: one-byte pattern of zero, zero bytes match
        add_item(8'h00, 1'b0);
        add_item(NEWLINE_CHAR, 1'b0);
        add_item(8'h41, 1'b0);
        add_item(NEWLINE_CHAR, 1'b0);
        add_item(8'hFF, 1'b1);
        // newline that also ends the text closes a single line
        add_item(NEWLINE_CHAR, 1'b1);
        add_item(8'h00, 1'b1);
        wait_quiet();
        setups_run++;

        // pattern "aB" plus newline, case ignored: the newline is part of the line
        write_reg(CFG_PAT_0_7, 64'h0000_0000_000A_4261);
        write_reg(CFG_PAT_LEN, PAT_WORD_W'(3));
        write_reg(CFG_IGN_CASE, PAT_WORD_W'(1));
        write_reg(CFG_SPARE_7, '1);
        end_writes();
        add_item(8'h78, 1'b0);
        add_item(8'h41, 1'b0);
        add_item(8'h62, 1'b0);
        add_item(NEWLINE_CHAR, 1'b0);
        add_item(8'h61, 1'b0);
        add_item(8'h62, 1'b1);
        wait_quiet();
        setups_run++;

        // empty pattern matches every line
        write_reg(CFG_PAT_LEN, '0);
        end_writes();
        add_item(NEWLINE_CHAR, 1'b0);
        add_item(8'h7A, 1'b1);
        wait_quiet();
        setups_run++;

        // case folding touches letters only
        write_reg(CFG_PAT_0_7, 64'h40);
        write_reg(CFG_PAT_LEN, PAT_WORD_W'(1));
        end_writes();
        add_item(8'h60, 1'b0);
        add_item(NEWLINE_CHAR, 1'b0);
        add_item(8'h40, 1'b0);
        add_item(NEWLINE_CHAR, 1'b0);
        wait_quiet();
        setups_run++;

        for (int k = 0; k < RAND_SETUPS; k++)
        begin
            run_random_setup(k);
        end

        wait_quiet();
        if (line_nums_due.size() != 0)
        begin
            $display("%0t: %0d line numbers never came out", $time, line_nums_due.size());
            errors++;
        end
        $display("covered %0d text bytes over %0d pattern setups, %0d line numbers checked",
                 items_seen, setups_run, results_checked);
        $display("lengths 0 to 63, exact and folded case, sender and receiver idling mixed");
        if (errors == 0)
        begin
            $display("[line_substring_search_core] OK");
        end
        else
        begin
            $display("[line_substring_search_core] ERROR");
        end
        $finish;
    end

endmodule
